FILE: rtl/rrpf_pkg.sv
// Shared types, widths and command/status codes of the range-rule packet filter.
package rrpf_pkg;

  localparam int MAX_RULES_DEF = 64;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 16;
  localparam int HITS_W        = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 3;
  localparam int RIDX_W        = 6;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FLUSHED   = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] low_addr;
    logic [ADDR_W-1:0] high_addr;
    logic [PORT_W-1:0] low_port;
    logic [PORT_W-1:0] high_port;
    logic [HITS_W-1:0] hits;
  } rule_t;

  // Per-cycle strobes broadcast from the sequencer to every rule cell
  typedef struct packed {
    logic capture;    // latch compare result against the incoming word
    logic is_delete;  // compare for identical ranges instead of containment
    logic do_add;     // cell at the fill point loads the new rule
    logic do_hit;     // selected cell loads the new hit count
    logic do_shift;   // cells at or after the deleted slot take the neighbor's rule
  } cell_ctl_t;

endpackage

FILE: rtl/range_rule_packet_filter_top.sv
// Top level of the range-rule packet filter: sequencer, rule cell row and result register.
//
// Usage: the input channel (in_valid/in_ready) carries one command word: add rule,
// check connection, delete rule or flush. Each word yields exactly one result word
// on the output channel (out_valid/out_ready): status, rule slot and hit count.
// Rules sit in a row of cells, one rule per cell, in insertion order. A check
// compares the key against every cell in parallel; the lowest matching cell wins.
// Delete finds the lowest identical rule; that cell and every later cell then take
// their upper neighbor's rule together.
// Timing: a word is compared in the cycle it is accepted, and the match bits are
// registered in the cells; the word is committed from the evaluate state once the
// result register is free, and out_valid rises at the commit edge. No new word is
// taken until the previous one commits; the compare-then-resolve pair sets this.
// The result register decouples the sides: the next word is accepted while an
// earlier result waits. If the receiver stalls, the block holds the commit stage
// and the table until the result register frees up.
// Reset (synchronous, active low) empties the table and drops any pending result;
// rule contents are not cleared, only the rule count.
module range_rule_packet_filter_top #(
  parameter int MAX_RULES = rrpf_pkg::MAX_RULES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rrpf_pkg::CMD_W-1:0]      in_command,
  input  logic [rrpf_pkg::ADDR_W-1:0]     in_start_ip,
  input  logic [rrpf_pkg::ADDR_W-1:0]     in_end_ip,
  input  logic [rrpf_pkg::PORT_W-1:0]     in_low_port,
  input  logic [rrpf_pkg::PORT_W-1:0]     in_high_port,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rrpf_pkg::STATUS_W-1:0]   out_status,
  output logic [rrpf_pkg::RIDX_W-1:0]     out_rule_index,
  output logic [rrpf_pkg::HITS_W-1:0]     out_hit_count
);
  import rrpf_pkg::*;

  localparam int IDX_W = $clog2(MAX_RULES);
  localparam int TOT_W = $clog2(MAX_RULES + 1);
  localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(MAX_RULES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic state_r, state_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  logic [CMD_W-1:0]  op_cmd_r;
  logic [ADDR_W-1:0] op_start_r, op_end_r;
  logic [PORT_W-1:0] op_lport_r, op_hport_r;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [RIDX_W-1:0]   out_index_r, out_index_nxt;
  logic [HITS_W-1:0]   out_hits_r, out_hits_nxt;

  logic accept, out_free, go, full;
  cell_ctl_t ctl;
  rule_t     new_rule;
  rule_t     cell_rule [MAX_RULES];
  rule_t     nbr [MAX_RULES];

  logic [MAX_RULES-1:0] match, lowbit, tail;
  logic [IDX_W-1:0]     first_idx;
  logic                 any;
  logic [HITS_W-1:0]    sel_hits, hits_next;
  logic [IDX_W+RIDX_W-1:0] idx_wide, add_wide;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign go       = (state_r == S_EVAL) && out_free;
  assign full     = (total_r == TOT_MAX);

  assign ctl.capture   = accept;
  assign ctl.is_delete = (in_command == CMD_DELETE);
  assign ctl.do_add    = go && (op_cmd_r == CMD_ADD) && !full;
  assign ctl.do_hit    = go && (op_cmd_r == CMD_CHECK) && any;
  assign ctl.do_shift  = go && (op_cmd_r == CMD_DELETE) && any;

  // Winning cell's hit count, saturating increment
  always_comb begin
    sel_hits = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      sel_hits = sel_hits | (lowbit[i] ? cell_rule[i].hits : '0);
    end
  end

  assign hits_next = (&sel_hits) ? sel_hits : sel_hits + HITS_W'(1);

  always_comb begin
    new_rule.low_addr  = op_start_r;
    new_rule.high_addr = op_end_r;
    new_rule.low_port  = op_lport_r;
    new_rule.high_port = op_hport_r;
    new_rule.hits      = (op_cmd_r == CMD_ADD) ? '0 : hits_next;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_RULES; g++) begin : g_cell
      if (g == MAX_RULES - 1) begin : g_last
        assign nbr[g] = '0;
      end else begin : g_mid
        assign nbr[g] = cell_rule[g+1];
      end

      rrpf_cell #(
        .CELL_IDX (g),
        .MAX_RULES(MAX_RULES)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .total    (total_r),
        .key_start(in_start_ip),
        .key_end  (in_end_ip),
        .key_lport(in_low_port),
        .key_hport(in_high_port),
        .new_rule (new_rule),
        .sel      (lowbit[g]),
        .shift_en (tail[g]),
        .nbr_rule (nbr[g]),
        .rule     (cell_rule[g]),
        .match    (match[g])
      );
    end
  endgenerate

  rrpf_first #(
    .MAX_RULES(MAX_RULES)
  ) u_first (
    .req   (match),
    .lowbit(lowbit),
    .tail  (tail),
    .idx   (first_idx),
    .any   (any)
  );

  assign idx_wide = (IDX_W + RIDX_W)'(first_idx);
  assign add_wide = (IDX_W + RIDX_W)'(total_r[IDX_W-1:0]);

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_hits_nxt   = out_hits_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      state_nxt = S_EVAL;
    end

    if (go) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      out_index_nxt = '0;
      out_hits_nxt  = '0;
      case (op_cmd_r)
        CMD_ADD: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_ADDED;
            out_index_nxt  = add_wide[RIDX_W-1:0];
            total_nxt      = total_r + TOT_W'(1);
          end
        end
        CMD_CHECK: begin
          if (any) begin
            out_status_nxt = ST_ACCEPTED;
            out_index_nxt  = idx_wide[RIDX_W-1:0];
            out_hits_nxt   = hits_next;
          end else begin
            out_status_nxt = ST_REJECTED;
          end
        end
        CMD_DELETE: begin
          if (any) begin
            out_status_nxt = ST_DELETED;
            out_index_nxt  = idx_wide[RIDX_W-1:0];
            total_nxt      = total_r - TOT_W'(1);
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          out_status_nxt = ST_FLUSHED;
          total_nxt      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_hits_r   <= out_hits_nxt;
    if (accept) begin
      op_cmd_r   <= in_command;
      op_start_r <= in_start_ip;
      op_end_r   <= in_end_ip;
      op_lport_r <= in_low_port;
      op_hport_r <= in_high_port;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rule_index = out_index_r;
  assign out_hit_count  = out_hits_r;

endmodule

FILE: rtl/rrpf_cell.sv
// One rule slot: holds a rule, compares it against a key, shifts down on delete.
module rrpf_cell #(
  parameter int CELL_IDX  = 0,
  parameter int MAX_RULES = rrpf_pkg::MAX_RULES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrpf_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(MAX_RULES+1)-1:0] total,
  input  logic [rrpf_pkg::ADDR_W-1:0]   key_start,
  input  logic [rrpf_pkg::ADDR_W-1:0]   key_end,
  input  logic [rrpf_pkg::PORT_W-1:0]   key_lport,
  input  logic [rrpf_pkg::PORT_W-1:0]   key_hport,
  input  rrpf_pkg::rule_t               new_rule,
  input  logic                          sel,
  input  logic                          shift_en,
  input  rrpf_pkg::rule_t               nbr_rule,
  output rrpf_pkg::rule_t               rule,
  output logic                          match
);
  import rrpf_pkg::*;

  localparam int TOT_W = $clog2(MAX_RULES + 1);
  localparam logic [TOT_W-1:0] MY_IDX = TOT_W'(CELL_IDX);

  rule_t rule_r, rule_nxt;
  logic  match_r, match_nxt;
  logic  in_use, contains, same;

  assign in_use = MY_IDX < total;

  assign contains = (key_start >= rule_r.low_addr) && (key_start <= rule_r.high_addr) &&
                    (key_lport >= rule_r.low_port) && (key_lport <= rule_r.high_port);

  assign same = (key_start == rule_r.low_addr) && (key_end == rule_r.high_addr) &&
                (key_lport == rule_r.low_port) && (key_hport == rule_r.high_port);

  always_comb begin
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = in_use && (ctl.is_delete ? same : contains);
    end
  end

  always_comb begin
    rule_nxt = rule_r;
    if (ctl.do_add && (MY_IDX == total)) begin
      rule_nxt = new_rule;
    end else if (ctl.do_hit && sel) begin
      rule_nxt.hits = new_rule.hits;
    end else if (ctl.do_shift && shift_en) begin
      rule_nxt = nbr_rule;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rule_r <= rule_nxt;
  end

  assign rule  = rule_r;
  assign match = match_r;

endmodule

FILE: rtl/rrpf_first.sv
// Lowest-set-bit finder over the cell match row: one-hot, tail mask and slot number.
module rrpf_first #(
  parameter int MAX_RULES = rrpf_pkg::MAX_RULES_DEF
) (
  input  logic [MAX_RULES-1:0]         req,
  output logic [MAX_RULES-1:0]         lowbit,
  output logic [MAX_RULES-1:0]         tail,
  output logic [$clog2(MAX_RULES)-1:0] idx,
  output logic                         any
);
  localparam int IDX_W = $clog2(MAX_RULES);

  // Two's complement isolates the lowest set bit; bits below it are lowbit - 1
  assign lowbit = req & (~req + MAX_RULES'(1));
  assign tail   = ~(lowbit - MAX_RULES'(1));
  assign any    = |req;

  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      idx = idx | (lowbit[i] ? IDX_W'(i) : '0);
    end
  end

endmodule

FILE: rtl/rrpf_checker.sv
// Port-level checker for the range-rule packet filter, bound to the top level.
module rrpf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrpf_pkg::STATUS_W-1:0] out_status,
  input logic [rrpf_pkg::RIDX_W-1:0]   out_rule_index,
  input logic [rrpf_pkg::HITS_W-1:0]   out_hit_count
);
  import rrpf_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_rule_index) && $stable(out_hit_count))
    else $error("stalled result word changed");

  // A word keeps the block busy for its commit cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FLUSHED)
    else $error("unused status code");

  a_hits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPTED |-> out_hit_count == '0)
    else $error("hit count on a non-match result");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_REJECTED ||
    out_status == ST_NOT_FOUND || out_status == ST_FLUSHED) |-> out_rule_index == '0)
    else $error("slot reported on a result without a slot");

endmodule

bind range_rule_packet_filter_top rrpf_checker u_rrpf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_rule_index(out_rule_index),
  .out_hit_count (out_hit_count)
);
